// ===== src/ax25_header_stream_parser_defines.svh =====
// Assertion macros used by the parser's result queue.
`ifndef AX25_HEADER_STREAM_PARSER_DEFINES_SVH
`define AX25_HEADER_STREAM_PARSER_DEFINES_SVH

// The condition must never hold at a clock edge outside reset.
`define AHSP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// When the trigger holds, the consequence must hold in the next cycle.
`define AHSP_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ahsp_pkg.sv =====
package ahsp_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_ADDR = 2'd0;
    localparam logic [1:0] KIND_CTRL = 2'd1;
    localparam logic [1:0] KIND_INFO = 2'd2;
    localparam logic [1:0] KIND_ERR  = 2'd3;

    // Address roles.
    localparam logic [1:0] ROLE_DEST = 2'd0;
    localparam logic [1:0] ROLE_SRC  = 2'd1;
    localparam logic [1:0] ROLE_RPT  = 2'd2;

    // Command/response classification.
    localparam logic [1:0] CR_CMD  = 2'd0;
    localparam logic [1:0] CR_RESP = 2'd1;
    localparam logic [1:0] CR_OLD  = 2'd2;

    // Frame types.
    localparam logic [3:0] FT_I       = 4'd0;
    localparam logic [3:0] FT_RR      = 4'd1;
    localparam logic [3:0] FT_SREJ    = 4'd4;
    localparam logic [3:0] FT_SABME   = 4'd5;
    localparam logic [3:0] FT_SABM    = 4'd6;
    localparam logic [3:0] FT_DISC    = 4'd7;
    localparam logic [3:0] FT_DM      = 4'd8;
    localparam logic [3:0] FT_UA      = 4'd9;
    localparam logic [3:0] FT_FRMR    = 4'd10;
    localparam logic [3:0] FT_UI      = 4'd11;
    localparam logic [3:0] FT_XID     = 4'd12;
    localparam logic [3:0] FT_TEST    = 4'd13;
    localparam logic [3:0] FT_UNKNOWN = 4'd14;

    // One result as it travels from the front end to the output stage.
    // The control word and mode are kept raw; the back end extracts the
    // sequence numbers and the poll/final bit.
    typedef struct packed {
        logic [1:0]  kind;
        logic [55:0] addr;
        logic [1:0]  role;
        logic [3:0]  hops;
        logic [1:0]  cr;
        logic [3:0]  ftype;
        logic [15:0] ctl;
        logic        ext;
        logic [7:0]  octet;
        logic        last;
    } rec_t;

endpackage

// ===== src/ax25_header_stream_parser.sv =====
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+-------------------------------------
// octets    | in        | in_valid / in_ready  | data_in, end_of_frame
// results   | out       | out_valid / out_ready| kind, addr_value ... data_byte, last
// config    | in        | cfg_write            | cfg_data (extended_mode)
//
// One octet is accepted per cycle while in_ready is high; a result that an octet causes
// passes through a queue entry, then the output register.
// in_ready drops only while the two-entry result queue between the front end and the
// output register is full; the front end and output stage stall independently.
// Reset is asynchronous and active low and needs no clearing pass.
module ax25_header_stream_parser #(
    parameter int MAX_REPEATERS = 8,
    parameter int CALL_CHARS    = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_in,
    input  logic        end_of_frame,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [55:0] addr_value,
    output logic [1:0]  addr_role,
    output logic [3:0]  hops,
    output logic [1:0]  cr,
    output logic [3:0]  frame_type,
    output logic [6:0]  nr,
    output logic [6:0]  ns,
    output logic        pf,
    output logic [7:0]  proto,
    output logic [7:0]  data_byte,
    output logic        last
);

    logic           accept;
    logic           push;
    logic           full;
    logic           pop;
    logic           empty;
    ahsp_pkg::rec_t push_rec;
    ahsp_pkg::rec_t pop_rec;

    // An octet request is taken whenever the queue has room.
    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    ahsp_front #(
        .MAX_REPEATERS (MAX_REPEATERS),
        .CALL_CHARS    (CALL_CHARS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .data_in      (data_in),
        .end_of_frame (end_of_frame),
        .push         (push),
        .push_rec     (push_rec)
    );

    ahsp_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .pop_rec  (pop_rec)
    );

    ahsp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (empty),
        .pop_rec    (pop_rec),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .addr_value (addr_value),
        .addr_role  (addr_role),
        .hops       (hops),
        .cr         (cr),
        .frame_type (frame_type),
        .nr         (nr),
        .ns         (ns),
        .pf         (pf),
        .proto      (proto),
        .data_byte  (data_byte),
        .last       (last)
    );

endmodule

// ===== src/ahsp_front.sv =====
module ahsp_front #(
    parameter int MAX_REPEATERS = 8,
    parameter int CALL_CHARS    = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic              cfg_data,
    input  logic              accept,
    input  logic [7:0]        data_in,
    input  logic              end_of_frame,
    output logic              push,
    output ahsp_pkg::rec_t    push_rec
);

    // Parse phases.
    localparam logic [2:0] PH_DEST = 3'd0;
    localparam logic [2:0] PH_SRC  = 3'd1;
    localparam logic [2:0] PH_RPT  = 3'd2;
    localparam logic [2:0] PH_CTL1 = 3'd3;
    localparam logic [2:0] PH_CTL2 = 3'd4;
    localparam logic [2:0] PH_PID  = 3'd5;
    localparam logic [2:0] PH_INFO = 3'd6;
    localparam logic [2:0] PH_DROP = 3'd7;

    // Callsign octets are ASCII shifted left by one; address octet seven is the SSID.
    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [2:0] LAST_OCTET = 3'd6;

    // Unnumbered control patterns with the poll/final bit masked off.
    localparam logic [7:0] U_MASK  = 8'hEF;
    localparam logic [7:0] U_SABME = 8'h6F;
    localparam logic [7:0] U_SABM  = 8'h2F;
    localparam logic [7:0] U_DISC  = 8'h43;
    localparam logic [7:0] U_DM    = 8'h0F;
    localparam logic [7:0] U_UA    = 8'h63;
    localparam logic [7:0] U_FRMR  = 8'h87;
    localparam logic [7:0] U_UI    = 8'h03;
    localparam logic [7:0] U_XID   = 8'hAF;
    localparam logic [7:0] U_TEST  = 8'hE3;

    logic [2:0]  phase_reg, phase_next;
    logic [2:0]  count_reg, count_next;
    logic        space_reg, space_next;
    logic [55:0] shift_reg, shift_next;
    logic        dest_c_reg, dest_c_next;
    logic [1:0]  cr_reg, cr_next;
    logic [3:0]  hop_reg, hop_next;
    logic [15:0] ctl_reg, ctl_next;
    logic [3:0]  type_reg, type_next;
    logic        ext_reg;

    logic        run_after;
    logic        give_err;
    logic        start;
    logic        bad;
    logic [6:0]  ch;
    logic [3:0]  hop_inc;
    logic [15:0] w_new;
    logic [3:0]  ft_new;

    function automatic logic char_ok(input logic [6:0] c);
        return (c >= 7'h41 && c <= 7'h5A) || (c >= 7'h30 && c <= 7'h39) || c == CH_SPACE;
    endfunction

    // Frame type from the control word.
    function automatic logic [3:0] classify(input logic [15:0] w);
        logic [3:0] t;
        t = ahsp_pkg::FT_UNKNOWN;
        if (!w[0]) begin
            t = ahsp_pkg::FT_I;
        end
        else if (w[1:0] == 2'b01) begin
            t = ahsp_pkg::FT_RR + {2'b00, w[3:2]};
        end
        else begin
            case (w[7:0] & U_MASK)
                U_SABME: t = ahsp_pkg::FT_SABME;
                U_SABM:  t = ahsp_pkg::FT_SABM;
                U_DISC:  t = ahsp_pkg::FT_DISC;
                U_DM:    t = ahsp_pkg::FT_DM;
                U_UA:    t = ahsp_pkg::FT_UA;
                U_FRMR:  t = ahsp_pkg::FT_FRMR;
                U_UI:    t = ahsp_pkg::FT_UI;
                U_XID:   t = ahsp_pkg::FT_XID;
                U_TEST:  t = ahsp_pkg::FT_TEST;
                default: t = ahsp_pkg::FT_UNKNOWN;
            endcase
        end
        return t;
    endfunction

    assign ch      = data_in[7:1];
    assign hop_inc = hop_reg + 4'd1;
    assign ft_new  = classify(w_new);

    // Per-octet parse step.
    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        space_next  = space_reg;
        shift_next  = shift_reg;
        dest_c_next = dest_c_reg;
        cr_next     = cr_reg;
        hop_next    = hop_reg;
        ctl_next    = ctl_reg;
        type_next   = type_reg;
        run_after   = 1'b0;
        give_err    = 1'b0;
        start       = 1'b0;
        bad         = 1'b0;
        w_new       = ctl_reg;
        push        = 1'b0;
        push_rec    = '0;
        push_rec.ext = ext_reg;

        if (accept)
        begin
            unique case (phase_reg)
                PH_DEST, PH_SRC, PH_RPT:
                begin
                    if (count_reg < 3'(CALL_CHARS))
                    begin
                        if (!char_ok(ch) || data_in[0])
                        begin
                            bad = 1'b1;
                        end
                        if (ch == CH_SPACE)
                        begin
                            space_next = 1'b1;
                        end
                        else if (space_reg)
                        begin
                            bad = 1'b1;
                        end
                    end
                    shift_next = {shift_reg[47:0], data_in};
                    if (bad || end_of_frame)
                    begin
                        give_err = 1'b1;
                    end
                    else if (count_reg < LAST_OCTET)
                    begin
                        count_next = count_reg + 3'd1;
                    end
                    else
                    begin
                        count_next    = 3'd0;
                        space_next    = 1'b0;
                        push_rec.kind = ahsp_pkg::KIND_ADDR;
                        push_rec.addr = shift_next;
                        if (phase_reg == PH_DEST)
                        begin
                            push          = 1'b1;
                            dest_c_next   = data_in[7];
                            push_rec.role = ahsp_pkg::ROLE_DEST;
                            phase_next    = PH_SRC;
                        end
                        else if (phase_reg == PH_SRC)
                        begin
                            push = 1'b1;
                            if (dest_c_reg != data_in[7])
                            begin
                                cr_next = dest_c_reg ? ahsp_pkg::CR_CMD : ahsp_pkg::CR_RESP;
                            end
                            else
                            begin
                                cr_next = ahsp_pkg::CR_OLD;
                            end
                            hop_next      = 4'd0;
                            push_rec.role = ahsp_pkg::ROLE_SRC;
                            push_rec.cr   = cr_next;
                            phase_next    = data_in[0] ? PH_CTL1 : PH_RPT;
                        end
                        else
                        begin
                            hop_next = hop_inc;
                            if (!data_in[0] && hop_inc >= 4'(MAX_REPEATERS))
                            begin
                                give_err = 1'b1;
                            end
                            else
                            begin
                                push          = 1'b1;
                                push_rec.role = ahsp_pkg::ROLE_RPT;
                                push_rec.hops = hop_inc;
                                push_rec.cr   = cr_reg;
                                phase_next    = data_in[0] ? PH_CTL1 : PH_RPT;
                            end
                        end
                    end
                end
                PH_CTL1:
                begin
                    w_new    = {8'h00, data_in};
                    ctl_next = w_new;
                    if (ext_reg && data_in[1:0] != 2'b11)
                    begin
                        if (end_of_frame)
                        begin
                            give_err = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_CTL2;
                        end
                    end
                    else
                    begin
                        run_after = 1'b1;
                    end
                end
                PH_CTL2:
                begin
                    w_new     = ctl_reg | {data_in, 8'h00};
                    ctl_next  = w_new;
                    run_after = 1'b1;
                end
                PH_PID:
                begin
                    push           = 1'b1;
                    push_rec.kind  = ahsp_pkg::KIND_CTRL;
                    push_rec.hops  = hop_reg;
                    push_rec.cr    = cr_reg;
                    push_rec.ftype = type_reg;
                    push_rec.ctl   = ctl_reg;
                    push_rec.octet = data_in;
                    push_rec.last  = end_of_frame;
                    if (end_of_frame)
                    begin
                        start = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_INFO;
                    end
                end
                PH_INFO:
                begin
                    push           = 1'b1;
                    push_rec.kind  = ahsp_pkg::KIND_INFO;
                    push_rec.octet = data_in;
                    push_rec.last  = end_of_frame;
                    start          = end_of_frame;
                end
                PH_DROP:
                begin
                    start = end_of_frame;
                end
                default:
                begin
                    start = end_of_frame;
                end
            endcase
        end

        // Control field complete: decide between PID, info and end of header.
        if (run_after)
        begin
            type_next = ft_new;
            if (ft_new == ahsp_pkg::FT_I || ft_new == ahsp_pkg::FT_UI)
            begin
                if (end_of_frame)
                begin
                    give_err = 1'b1;
                end
                else
                begin
                    phase_next = PH_PID;
                end
            end
            else
            begin
                push           = 1'b1;
                push_rec.kind  = ahsp_pkg::KIND_CTRL;
                push_rec.hops  = hop_reg;
                push_rec.cr    = cr_reg;
                push_rec.ftype = ft_new;
                push_rec.ctl   = w_new;
                if (ft_new == ahsp_pkg::FT_TEST && !end_of_frame)
                begin
                    phase_next = PH_INFO;
                end
                else
                begin
                    push_rec.last = 1'b1;
                    if (end_of_frame)
                    begin
                        start = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_DROP;
                    end
                end
            end
        end

        // Error result, then drop the rest of the frame. An error on a repeater
        // beyond the limit still carries that repeater's address octets.
        if (give_err)
        begin
            push      = 1'b1;
            push_rec.kind = ahsp_pkg::KIND_ERR;
            push_rec.last = 1'b1;
            if (end_of_frame)
            begin
                start = 1'b1;
            end
            else
            begin
                phase_next = PH_DROP;
            end
        end

        // Return to the start of a new frame.
        if (start)
        begin
            phase_next = PH_DEST;
            count_next = 3'd0;
            space_next = 1'b0;
            hop_next   = 4'd0;
            shift_next = '0;
        end
    end

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_DEST;
            count_reg  <= 3'd0;
            space_reg  <= 1'b0;
            shift_reg  <= '0;
            dest_c_reg <= 1'b0;
            cr_reg     <= ahsp_pkg::CR_CMD;
            hop_reg    <= 4'd0;
            ctl_reg    <= 16'h0000;
            type_reg   <= ahsp_pkg::FT_UNKNOWN;
            ext_reg    <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            space_reg  <= space_next;
            shift_reg  <= shift_next;
            dest_c_reg <= dest_c_next;
            cr_reg     <= cr_next;
            hop_reg    <= hop_next;
            ctl_reg    <= ctl_next;
            type_reg   <= type_next;
            if (cfg_write)
            begin
                ext_reg <= cfg_data;
            end
        end
    end

endmodule

// ===== src/ahsp_fifo.sv =====
`include "ax25_header_stream_parser_defines.svh"

module ahsp_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ahsp_pkg::rec_t push_rec,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output ahsp_pkg::rec_t pop_rec
);

    localparam int DEPTH = 2;

    ahsp_pkg::rec_t mem_reg [DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full    = (count_reg == 2'(DEPTH));
    assign empty   = (count_reg == 2'd0);
    assign pop_rec = mem_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    `AHSP_ASSERT_NEVER(a_count_range, clk, rst_n, count_reg > 2'(DEPTH), "queue count overflow")
    `AHSP_ASSERT_NEVER(a_push_full, clk, rst_n, push && full, "push into full queue")
    `AHSP_ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && empty, "pop from empty queue")
    `AHSP_ASSERT_NEXT(a_push_grows, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 2'd1, "queue count did not grow")

endmodule

// ===== src/ahsp_back.sv =====
module ahsp_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           empty,
    input  ahsp_pkg::rec_t pop_rec,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [1:0]     kind,
    output logic [55:0]    addr_value,
    output logic [1:0]     addr_role,
    output logic [3:0]     hops,
    output logic [1:0]     cr,
    output logic [3:0]     frame_type,
    output logic [6:0]     nr,
    output logic [6:0]     ns,
    output logic           pf,
    output logic [7:0]     proto,
    output logic [7:0]     data_byte,
    output logic           last
);

    logic        valid_reg;
    logic [1:0]  kind_reg, kind_next;
    logic [55:0] addr_reg, addr_next;
    logic [1:0]  role_reg, role_next;
    logic [3:0]  hops_reg, hops_next;
    logic [1:0]  cr_reg, cr_next;
    logic [3:0]  ftype_reg, ftype_next;
    logic [6:0]  nr_reg, nr_next;
    logic [6:0]  ns_reg, ns_next;
    logic        pf_reg, pf_next;
    logic [7:0]  proto_reg, proto_next;
    logic [7:0]  data_reg, data_next;
    logic        last_reg, last_next;

    // Load the output register when it is free or being taken.
    assign pop = !empty && (!valid_reg || out_ready);

    // Field extraction by result kind; fields that do not apply are zero.
    always_comb
    begin
        kind_next  = pop_rec.kind;
        addr_next  = '0;
        role_next  = '0;
        hops_next  = '0;
        cr_next    = '0;
        ftype_next = '0;
        nr_next    = '0;
        ns_next    = '0;
        pf_next    = 1'b0;
        proto_next = '0;
        data_next  = '0;
        last_next  = pop_rec.last;
        unique case (pop_rec.kind)
            ahsp_pkg::KIND_ADDR:
            begin
                addr_next = pop_rec.addr;
                role_next = pop_rec.role;
                hops_next = pop_rec.hops;
                cr_next   = pop_rec.cr;
            end
            ahsp_pkg::KIND_CTRL:
            begin
                hops_next  = pop_rec.hops;
                cr_next    = pop_rec.cr;
                ftype_next = pop_rec.ftype;
                proto_next = pop_rec.octet;
                if (pop_rec.ftype <= ahsp_pkg::FT_SREJ)
                begin
                    nr_next = pop_rec.ext ? pop_rec.ctl[15:9] : {4'b0000, pop_rec.ctl[7:5]};
                    pf_next = pop_rec.ext ? pop_rec.ctl[8] : pop_rec.ctl[4];
                    if (pop_rec.ftype == ahsp_pkg::FT_I)
                    begin
                        ns_next = pop_rec.ext ? pop_rec.ctl[7:1] : {4'b0000, pop_rec.ctl[3:1]};
                    end
                end
                else if (pop_rec.ftype != ahsp_pkg::FT_UNKNOWN)
                begin
                    pf_next = pop_rec.ctl[4];
                end
            end
            ahsp_pkg::KIND_INFO:
            begin
                data_next = pop_rec.octet;
            end
            ahsp_pkg::KIND_ERR:
            begin
                // The address octets stay on an error for a repeater over the limit.
                addr_next = pop_rec.addr;
                last_next = 1'b1;
            end
            default:
            begin
                last_next = pop_rec.last;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg  <= kind_next;
            addr_reg  <= addr_next;
            role_reg  <= role_next;
            hops_reg  <= hops_next;
            cr_reg    <= cr_next;
            ftype_reg <= ftype_next;
            nr_reg    <= nr_next;
            ns_reg    <= ns_next;
            pf_reg    <= pf_next;
            proto_reg <= proto_next;
            data_reg  <= data_next;
            last_reg  <= last_next;
        end
    end

    assign out_valid  = valid_reg;
    assign kind       = kind_reg;
    assign addr_value = addr_reg;
    assign addr_role  = role_reg;
    assign hops       = hops_reg;
    assign cr         = cr_reg;
    assign frame_type = ftype_reg;
    assign nr         = nr_reg;
    assign ns         = ns_reg;
    assign pf         = pf_reg;
    assign proto      = proto_reg;
    assign data_byte  = data_reg;
    assign last       = last_reg;

endmodule

// ===== tb/ax25_header_stream_parser_test.sv =====
`timescale 1ns / 100ps

module ax25_header_stream_parser_test;

    localparam int MAX_REPEATERS   = 8;
    localparam int CALL_CHARS      = 6;
    localparam int STALL_LIMIT     = 5000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_OFF_AT     = 120;

    // Unnumbered control codes with the poll/final bit cleared.
    localparam logic [7:0] PF_CLEAR = 8'hEF;
    localparam logic [7:0] U_SABME  = 8'h6F;
    localparam logic [7:0] U_SABM   = 8'h2F;
    localparam logic [7:0] U_DISC   = 8'h43;
    localparam logic [7:0] U_DM     = 8'h0F;
    localparam logic [7:0] U_UA     = 8'h63;
    localparam logic [7:0] U_FRMR   = 8'h87;
    localparam logic [7:0] U_UI     = 8'h03;
    localparam logic [7:0] U_XID    = 8'hAF;
    localparam logic [7:0] U_TEST   = 8'hE3;

    // A space character as it sits in an address octet.
    localparam logic [7:0] SPACE_OCTET = 8'h40;

    typedef enum logic [2:0] {
        AWAIT_DEST,
        AWAIT_SRC,
        AWAIT_RPT,
        AWAIT_CTL1,
        AWAIT_CTL2,
        AWAIT_PID,
        PASS_INFO,
        SKIP_REST
    } parse_phase_t;

    typedef struct packed {
        logic [7:0] octet;
        logic       eof;
    } frame_octet_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [55:0] addr_value;
        logic [1:0]  addr_role;
        logic [3:0]  hops;
        logic [1:0]  cr;
        logic [3:0]  frame_type;
        logic [6:0]  nr;
        logic [6:0]  ns;
        logic        pf;
        logic [7:0]  proto;
        logic [7:0]  data_byte;
        logic        last;
    } header_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic        cfg_data = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_in = 8'h00;
    logic        end_of_frame = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic [55:0] addr_value;
    logic [1:0]  addr_role;
    logic [3:0]  hops;
    logic [1:0]  cr;
    logic [3:0]  frame_type;
    logic [6:0]  nr;
    logic [6:0]  ns;
    logic        pf;
    logic [7:0]  proto;
    logic [7:0]  data_byte;
    logic        last;

    frame_octet_t   pending_octets[$];
    header_result_t expected_results[$];
    logic [7:0]     frame_bytes[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count = 0;
    int results_seen = 0;
    int hold_left = 0;
    bit hold_done = 0;
    int idle_cycles = 0;

    // Parser state mirrored by the predictor.
    logic         ext_mode;
    parse_phase_t phase;
    logic [2:0]   call_pos;
    logic         spaces_started;
    logic [55:0]  addr_shift;
    logic         dest_c;
    logic [1:0]   cr_class;
    logic [3:0]   repeater_count;
    logic [15:0]  ctl_word;
    logic [3:0]   ftype;

    ax25_header_stream_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_in      (data_in),
        .end_of_frame (end_of_frame),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .addr_value   (addr_value),
        .addr_role    (addr_role),
        .hops         (hops),
        .cr           (cr),
        .frame_type   (frame_type),
        .nr           (nr),
        .ns           (ns),
        .pf           (pf),
        .proto        (proto),
        .data_byte    (data_byte),
        .last         (last)
    );

    always #4 clk = ~clk;

    function automatic void restart_frame();
        phase = AWAIT_DEST;
        call_pos = 3'd0;
        spaces_started = 1'b0;
        repeater_count = 4'd0;
        addr_shift = '0;
    endfunction

    function automatic void raise_error(input logic eof, inout header_result_t r);
        r.kind = ahsp_pkg::KIND_ERR;
        r.last = 1'b1;
        if (eof)
            restart_frame();
        else
            phase = SKIP_REST;
    endfunction

    function automatic bit callsign_char(input logic [6:0] c);
        return (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") || c == " ";
    endfunction

    function automatic logic [3:0] control_type(input logic [15:0] w);
        if (!w[0])
            return ahsp_pkg::FT_I;
        if (w[1:0] == 2'b01)
            return ahsp_pkg::FT_RR + {2'b00, w[3:2]};
        case (w[7:0] & PF_CLEAR)
            U_SABME: return ahsp_pkg::FT_SABME;
            U_SABM:  return ahsp_pkg::FT_SABM;
            U_DISC:  return ahsp_pkg::FT_DISC;
            U_DM:    return ahsp_pkg::FT_DM;
            U_UA:    return ahsp_pkg::FT_UA;
            U_FRMR:  return ahsp_pkg::FT_FRMR;
            U_UI:    return ahsp_pkg::FT_UI;
            U_XID:   return ahsp_pkg::FT_XID;
            U_TEST:  return ahsp_pkg::FT_TEST;
            default: return ahsp_pkg::FT_UNKNOWN;
        endcase
    endfunction

    // Subfield layout depends on the modulus; U frames keep P/F in bit 4.
    function automatic void put_control_fields(input logic [7:0] pid, input logic fin,
                                               inout header_result_t r);
        r.kind = ahsp_pkg::KIND_CTRL;
        r.hops = repeater_count;
        r.cr = cr_class;
        r.frame_type = ftype;
        r.proto = pid;
        r.last = fin;
        if (ftype <= ahsp_pkg::FT_SREJ)
        begin
            r.nr = ext_mode ? ctl_word[15:9] : {4'b0000, ctl_word[7:5]};
            r.pf = ext_mode ? ctl_word[8] : ctl_word[4];
            if (ftype == ahsp_pkg::FT_I)
                r.ns = ext_mode ? ctl_word[7:1] : {4'b0000, ctl_word[3:1]};
        end
        else if (ftype != ahsp_pkg::FT_UNKNOWN)
        begin
            r.pf = ctl_word[4];
        end
    endfunction

    // Once the whole control field is in: I and UI wait for the PID octet.
    function automatic bit control_complete(input logic eof, inout header_result_t r);
        ftype = control_type(ctl_word);
        if (ftype == ahsp_pkg::FT_I || ftype == ahsp_pkg::FT_UI)
        begin
            if (eof)
            begin
                raise_error(1'b1, r);
                return 1'b1;
            end
            phase = AWAIT_PID;
            return 1'b0;
        end
        if (ftype == ahsp_pkg::FT_TEST && !eof)
        begin
            put_control_fields(8'h00, 1'b0, r);
            phase = PASS_INFO;
            return 1'b1;
        end
        put_control_fields(8'h00, 1'b1, r);
        if (eof)
            restart_frame();
        else
            phase = SKIP_REST;
        return 1'b1;
    endfunction

    // Advances the parser by one octet; returns 1 when a result comes out.
    function automatic bit decode_octet(input logic [7:0] b, input logic eof,
                                        output header_result_t r);
        logic       bad;
        logic [6:0] c;
        r = '0;
        case (phase)
            AWAIT_DEST, AWAIT_SRC, AWAIT_RPT:
            begin
                bad = 1'b0;
                c = b[7:1];
                if (call_pos < CALL_CHARS)
                begin
                    if (!callsign_char(c) || b[0])
                        bad = 1'b1;
                    if (c == " ")
                        spaces_started = 1'b1;
                    else if (spaces_started)
                        bad = 1'b1;
                end
                addr_shift = {addr_shift[47:0], b};
                if (bad || eof)
                begin
                    raise_error(eof, r);
                    return 1'b1;
                end
                if (call_pos < 3'd6)
                begin
                    call_pos++;
                    return 1'b0;
                end
                call_pos = 3'd0;
                spaces_started = 1'b0;
                r.kind = ahsp_pkg::KIND_ADDR;
                r.addr_value = addr_shift;
                if (phase == AWAIT_DEST)
                begin
                    dest_c = b[7];
                    r.addr_role = ahsp_pkg::ROLE_DEST;
                    phase = AWAIT_SRC;
                end
                else if (phase == AWAIT_SRC)
                begin
                    if (dest_c != b[7])
                        cr_class = dest_c ? ahsp_pkg::CR_CMD : ahsp_pkg::CR_RESP;
                    else
                        cr_class = ahsp_pkg::CR_OLD;
                    repeater_count = 4'd0;
                    r.addr_role = ahsp_pkg::ROLE_SRC;
                    r.cr = cr_class;
                    phase = b[0] ? AWAIT_CTL1 : AWAIT_RPT;
                end
                else
                begin
                    // The error result still carries the address octets.
                    repeater_count = repeater_count + 4'd1;
                    if (!b[0] && repeater_count >= MAX_REPEATERS)
                    begin
                        raise_error(1'b0, r);
                        return 1'b1;
                    end
                    r.addr_role = ahsp_pkg::ROLE_RPT;
                    r.hops = repeater_count;
                    r.cr = cr_class;
                    phase = b[0] ? AWAIT_CTL1 : AWAIT_RPT;
                end
                return 1'b1;
            end
            AWAIT_CTL1:
            begin
                ctl_word = {8'h00, b};
                if (ext_mode && b[1:0] != 2'b11)
                begin
                    if (eof)
                    begin
                        raise_error(1'b1, r);
                        return 1'b1;
                    end
                    phase = AWAIT_CTL2;
                    return 1'b0;
                end
                return control_complete(eof, r);
            end
            AWAIT_CTL2:
            begin
                ctl_word[15:8] = b;
                return control_complete(eof, r);
            end
            AWAIT_PID:
            begin
                put_control_fields(b, eof, r);
                if (eof)
                    restart_frame();
                else
                    phase = PASS_INFO;
                return 1'b1;
            end
            PASS_INFO:
            begin
                r.kind = ahsp_pkg::KIND_INFO;
                r.data_byte = b;
                r.last = eof;
                if (eof)
                    restart_frame();
                return 1'b1;
            end
            default:
            begin
                if (eof)
                    restart_frame();
                return 1'b0;
            end
        endcase
    endfunction

    // Six characters, first in the top byte, shifted into address octets.
    function automatic void add_address(input logic [47:0] call, input logic [7:0] ssid);
        logic [7:0] ch;
        for (int i = 0; i < 6; i++)
        begin
            ch = call[47 - 8 * i -: 8];
            frame_bytes.push_back({ch[6:0], 1'b0});
        end
        frame_bytes.push_back(ssid);
    endfunction

    function automatic logic [47:0] random_call();
        logic [47:0] call;
        int          len;
        int          pick;
        len = $urandom_range(0, 6);
        for (int i = 0; i < 6; i++)
        begin
            pick = $urandom_range(0, 35);
            if (i >= len)
                call[47 - 8 * i -: 8] = " ";
            else if (pick < 26)
                call[47 - 8 * i -: 8] = 8'("A" + pick);
            else
                call[47 - 8 * i -: 8] = 8'("0" + pick - 26);
        end
        return call;
    endfunction

    // Hands the assembled frame to the driver, end mark on its final octet.
    function automatic int commit_frame();
        int n = frame_bytes.size();
        for (int i = 0; i < n; i++)
            pending_octets.push_back({frame_bytes[i], 1'(i == n - 1)});
        frame_bytes.delete();
        return n;
    endfunction

    // A frame with random addresses, control field and payload; a full repeater list may lack its end mark.
    function automatic void build_frame(input logic ext_sel);
        int         n_rpt;
        int         pick;
        int         n_tail;
        logic [7:0] ssid;
        logic [7:0] ctl0;
        logic [7:0] u;
        logic [6:0] nr7;
        logic [6:0] ns7;
        logic [1:0] ss;
        logic       pfb;
        bit         with_pid;
        bit         with_info;
        frame_bytes.delete();
        n_rpt = ($urandom_range(0, 7) == 0) ? $urandom_range(3, MAX_REPEATERS)
                                              : $urandom_range(0, 2);
        // The destination SSID is never checked, so any octet goes.
        add_address(random_call(), 8'($urandom));
        ssid = 8'($urandom);
        ssid[0] = (n_rpt == 0);
        add_address(random_call(), ssid);
        for (int i = 1; i <= n_rpt; i++)
        begin
            ssid = 8'($urandom);
            ssid[0] = (i == n_rpt) && !(i == MAX_REPEATERS && $urandom_range(0, 1) == 0);
            add_address(random_call(), ssid);
        end
        nr7 = 7'($urandom);
        ns7 = 7'($urandom);
        ss = 2'($urandom);
        pfb = 1'($urandom);
        ctl0 = 8'($urandom);
        with_pid = 0;
        with_info = 0;
        pick = $urandom_range(0, 9);
        if (pick < 3)
        begin
            if (ext_sel)
            begin
                frame_bytes.push_back({ns7, 1'b0});
                frame_bytes.push_back({nr7, pfb});
            end
            else
            begin
                frame_bytes.push_back({nr7[2:0], pfb, ns7[2:0], 1'b0});
            end
            with_pid = 1;
            with_info = 1;
        end
        else if (pick < 5)
        begin
            if (ext_sel)
            begin
                frame_bytes.push_back({ctl0[7:4], ss, 2'b01});
                frame_bytes.push_back({nr7, pfb});
            end
            else
            begin
                frame_bytes.push_back({nr7[2:0], pfb, ss, 2'b01});
            end
        end
        else if (pick < 9)
        begin
            case ($urandom_range(0, 8))
                0: u = U_SABME;
                1: u = U_SABM;
                2: u = U_DISC;
                3: u = U_DM;
                4: u = U_UA;
                5: u = U_FRMR;
                6: u = U_UI;
                7: u = U_XID;
                default: u = U_TEST;
            endcase
            frame_bytes.push_back(u | {3'b000, pfb, 4'b0000});
            with_pid = (u == U_UI);
            with_info = (u == U_UI || u == U_TEST);
        end
        else
        begin
            do
                u = 8'($urandom) | 8'h03;
            while (control_type({8'h00, u}) != ahsp_pkg::FT_UNKNOWN);
            frame_bytes.push_back(u);
        end
        if (with_pid)
            frame_bytes.push_back(8'($urandom));
        n_tail = with_info ? $urandom_range(0, 6)
                           : (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
        repeat (n_tail) frame_bytes.push_back(8'($urandom));
    endfunction

    // Mostly good frames; the rest are cut short, corrupted or pure noise.
    function automatic int queue_frame(input logic ext_sel);
        int pick;
        int idx;
        pick = $urandom_range(0, 19);
        if (pick == 19)
        begin
            frame_bytes.delete();
            repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom));
        end
        else
        begin
            build_frame(ext_sel);
            if (pick == 16)
            begin
                idx = $urandom_range(1, frame_bytes.size());
                while (frame_bytes.size() > idx)
                    void'(frame_bytes.pop_back());
            end
            else if (pick >= 17)
            begin
                idx = $urandom_range(0, 13);
                frame_bytes[idx] = (pick == 17) ? 8'($urandom) : SPACE_OCTET;
            end
        end
        return commit_frame();
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    task automatic program_mode(input logic mode);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= mode;
        @(posedge clk);
        cfg_write <= 1'b0;
        ext_mode = mode;
    endtask

    // Wait until every octet request is taken and every result is checked.
    task automatic wait_for_idle();
        while (pending_octets.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Octet driver: predicts on acceptance, then offers the next request.
    always @(posedge clk or negedge rst_n)
    begin : octet_driver
        header_result_t res;
        frame_octet_t   next_octet;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            data_in <= 8'h00;
            end_of_frame <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready && decode_octet(data_in, end_of_frame, res))
                expected_results.push_back(res);
            if ((!in_valid || in_ready) && pending_octets.size() != 0
                && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_octet = pending_octets.pop_front();
                in_valid <= 1'b1;
                data_in <= next_octet.octet;
                end_of_frame <= next_octet.eof;
            end
            else if (in_ready)
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: compares each accepted request with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        header_result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing expected: kind %0d", kind);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("kind", want.kind, kind);
                    check_field("addr_value", want.addr_value, addr_value);
                    check_field("addr_role", want.addr_role, addr_role);
                    check_field("hops", want.hops, hops);
                    check_field("cr", want.cr, cr);
                    check_field("frame_type", want.frame_type, frame_type);
                    check_field("nr", want.nr, nr);
                    check_field("ns", want.ns, ns);
                    check_field("pf", want.pf, pf);
                    check_field("proto", want.proto, proto);
                    check_field("data_byte", want.data_byte, data_byte);
                    check_field("last", want.last, last);
                    results_seen++;
                end
            end
            // One long hold-off lets the block back up and stall its input.
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!hold_done && results_seen == HOLD_OFF_AT)
            begin
                hold_left = HOLD_OFF_CYCLES;
                hold_done = 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog on cycles in which neither side moves a request.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles == STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int octets;
        ext_mode = 1'b0;
        restart_frame();
        dest_c = 1'b0;
        cr_class = ahsp_pkg::CR_CMD;
        ctl_word = 16'h0000;
        ftype = ahsp_pkg::FT_UNKNOWN;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < 4; p++)
        begin
            program_mode(p[0]);
            case (p)
                0:
                begin
                    send_idle_pct = 36;
                    recv_idle_pct = 62;
                end
                1:
                begin
                    send_idle_pct = 62;
                    recv_idle_pct = 36;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            if (p == 0)
            begin
                // UI frame: trailing spaces, extreme characters, command, PID and info.
                add_address("AZ09  ", 8'hE0);
                add_address("Z9Z9Z9", 8'h61);
                frame_bytes.push_back(U_UI | 8'h10);
                frame_bytes.push_back(8'hF0);
                frame_bytes.push_back(8'hFF);
                frame_bytes.push_back(8'h00);
                void'(commit_frame());
                // Extension bit set in a callsign octet, then a dropped octet.
                frame_bytes.push_back(8'h83);
                frame_bytes.push_back(8'h00);
                void'(commit_frame());
                // A letter after a padding space.
                frame_bytes.push_back(SPACE_OCTET);
                frame_bytes.push_back(8'h82);
                frame_bytes.push_back(8'hFF);
                void'(commit_frame());
                // Frame that ends on its first octet.
                frame_bytes.push_back(8'h82);
                void'(commit_frame());
            end

            octets = 0;
            while (octets < ((p < 2) ? 320 : 180))
                octets += queue_frame(p[0]);
            wait_for_idle();
        end

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
